/* rtl/bitmap_rect_fill_engine_assert.svh */
// assertion macros for the rtl, included by brfe_ctrl
`ifndef BITMAP_RECT_FILL_ENGINE_ASSERT_SVH
`define BITMAP_RECT_FILL_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define BRFE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("brfe assertion failed");
`define BRFE_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("brfe assertion failed");
`else
`define BRFE_ASSERT(lbl, clk, rst_n, prop)
`define BRFE_ASSERT_NR(lbl, clk, prop)
`endif

`endif

/* rtl/brfe_pkg.sv */
package brfe_pkg;

    localparam int ADDR_W = 14;

    localparam logic [1:0] REQ_FILL  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    localparam logic [1:0] PM_SET    = 2'd0;
    localparam logic [1:0] PM_RESET  = 2'd1;
    localparam logic [1:0] PM_INVERT = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  x_first;
        logic [7:0]  y_first;
        logic [7:0]  x_second;
        logic [7:0]  y_second;
        logic [12:0] byte_address;
        logic [7:0]  byte_value;
    } t_req;

    typedef struct packed {
        logic [1:0] request_echo;
        logic [7:0] read_value;
    } t_res;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
    } t_mem_req;

    typedef struct packed {
        logic vld;
        t_res res;
    } t_done;

endpackage

/* rtl/brfe_mem.sv */
module brfe_mem
    import brfe_pkg::*;
#(
    parameter int BITMAP_BYTES = 6144
) (
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [7:0] o_rd_data
);

    localparam int AW = $clog2(BITMAP_BYTES);

    logic [7:0] r_mem [BITMAP_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/brfe_ctrl.sv */
`include "bitmap_rect_fill_engine_assert.svh"

module brfe_ctrl
    import brfe_pkg::*;
#(
    parameter int BITMAP_BYTES = 6144
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_req       i_req,
    input  logic [1:0] i_pix_op,
    input  logic [7:0] i_rd_data,
    output t_mem_req   o_mem,
    output t_done      o_done,
    output logic       o_busy
);

    localparam int AW = $clog2(BITMAP_BYTES);
    localparam logic [ADDR_W:0] LIMIT = (ADDR_W + 1)'(BITMAP_BYTES);
    localparam logic [AW-1:0] LAST = AW'(BITMAP_BYTES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_FWB  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_RDW  = 3'd5;
    localparam logic [2:0] S_WR   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic              r_boot, n_boot;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_wb_vld, n_wb_vld;
    logic [ADDR_W-1:0] r_wb_addr, n_wb_addr;
    logic [7:0]        r_wb_mask, n_wb_mask;
    logic [1:0]        r_type, n_type;
    logic [12:0]       r_addr, n_addr;
    logic              r_inr, n_inr;
    logic [7:0]        r_val, n_val;
    logic [7:0]        r_yb, n_yb;
    logic [4:0]        r_cx0, n_cx0;
    logic [4:0]        r_cx1, n_cx1;
    logic [2:0]        r_b0, n_b0;
    logic [2:0]        r_b1, n_b1;
    logic [7:0]        r_row, n_row;
    logic [4:0]        r_col, n_col;

    logic [7:0]        xa, xb, ya, yb;
    logic [ADDR_W-1:0] f_addr;
    logic              f_inr;
    logic [7:0]        m_lo, m_hi;
    logic [7:0]        wb_data;

    assign xa = (i_req.x_second < i_req.x_first) ? i_req.x_second : i_req.x_first;
    assign xb = (i_req.x_second < i_req.x_first) ? i_req.x_first : i_req.x_second;
    assign ya = (i_req.y_second < i_req.y_first) ? i_req.y_second : i_req.y_first;
    assign yb = (i_req.y_second < i_req.y_first) ? i_req.y_first : i_req.y_second;

    // tiled layout: 8-row bands of 256 bytes, 8 bytes per column
    assign f_addr = {1'b0, r_row[7:3], r_col, r_row[2:0]};
    assign f_inr  = {1'b0, f_addr} < LIMIT;
    assign m_lo   = (r_col == r_cx0) ? (8'hFF >> r_b0) : 8'hFF;
    assign m_hi   = (r_col == r_cx1) ? (8'hFF << (3'd7 - r_b1)) : 8'hFF;

    always_comb begin
        case (i_pix_op)
            PM_RESET:  wb_data = i_rd_data & ~r_wb_mask;
            PM_INVERT: wb_data = i_rd_data ^ r_wb_mask;
            default:   wb_data = i_rd_data | r_wb_mask;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_boot    = r_boot;
        n_clr     = r_clr;
        n_wb_vld  = 1'b0;
        n_wb_addr = r_wb_addr;
        n_wb_mask = r_wb_mask;
        n_type    = r_type;
        n_addr    = r_addr;
        n_inr     = r_inr;
        n_val     = r_val;
        n_yb      = r_yb;
        n_cx0     = r_cx0;
        n_cx1     = r_cx1;
        n_b0      = r_b0;
        n_b1      = r_b1;
        n_row     = r_row;
        n_col     = r_col;

        o_mem.rd_en   = 1'b0;
        o_mem.rd_addr = f_addr;
        o_mem.wr_en   = r_wb_vld;
        o_mem.wr_addr = r_wb_addr;
        o_mem.wr_data = wb_data;

        o_done.vld              = 1'b0;
        o_done.res.request_echo = r_type;
        o_done.res.read_value   = 8'h00;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_type = i_req.req_type;
                    n_addr = i_req.byte_address;
                    n_inr  = {2'b00, i_req.byte_address} < LIMIT;
                    n_val  = i_req.byte_value;
                    n_yb   = yb;
                    n_cx0  = xa[7:3];
                    n_cx1  = xb[7:3];
                    n_b0   = xa[2:0];
                    n_b1   = xb[2:0];
                    n_row  = ya;
                    n_col  = xa[7:3];
                    n_clr  = '0;
                    unique case (i_req.req_type)
                        REQ_FILL:  n_state = S_FILL;
                        REQ_CLEAR: n_state = S_CLR;
                        REQ_READ:  n_state = S_RD;
                        REQ_WRITE: n_state = S_WR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = ADDR_W'(r_clr);
                o_mem.wr_data = 8'h00;
                if (r_clr == LAST) begin
                    o_done.vld = !r_boot;
                    n_boot     = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_FILL: begin
                o_mem.rd_en = f_inr;
                n_wb_vld    = f_inr;
                n_wb_addr   = f_addr;
                n_wb_mask   = m_lo & m_hi;
                if (r_col == r_cx1) begin
                    n_col = r_cx0;
                    if (r_row == r_yb) begin
                        n_state = S_FWB;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_FWB: begin
                o_done.vld = 1'b1;
                n_state    = S_IDLE;
            end
            S_RD: begin
                o_mem.rd_en   = r_inr;
                o_mem.rd_addr = {1'b0, r_addr};
                n_state       = S_RDW;
            end
            S_RDW: begin
                o_done.vld            = 1'b1;
                o_done.res.read_value = r_inr ? i_rd_data : 8'h00;
                n_state               = S_IDLE;
            end
            S_WR: begin
                o_mem.wr_en   = r_inr;
                o_mem.wr_addr = {1'b0, r_addr};
                o_mem.wr_data = r_val;
                o_done.vld    = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_boot   <= 1'b1;
            r_clr    <= '0;
            r_wb_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_boot   <= n_boot;
            r_clr    <= n_clr;
            r_wb_vld <= n_wb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= n_wb_addr;
        r_wb_mask <= n_wb_mask;
        r_type    <= n_type;
        r_addr    <= n_addr;
        r_inr     <= n_inr;
        r_val     <= n_val;
        r_yb      <= n_yb;
        r_cx0     <= n_cx0;
        r_cx1     <= n_cx1;
        r_b0      <= n_b0;
        r_b1      <= n_b1;
        r_row     <= n_row;
        r_col     <= n_col;
    end

    `BRFE_ASSERT(a_rw_distinct, i_clk, i_rst_n, (o_mem.wr_en && o_mem.rd_en) |-> (o_mem.wr_addr != o_mem.rd_addr))
    `BRFE_ASSERT(a_done_idle, i_clk, i_rst_n, o_done.vld |=> (r_state == S_IDLE))
    `BRFE_ASSERT(a_fill_bounds, i_clk, i_rst_n, (r_state == S_FILL) |-> (r_col <= r_cx1 && r_row <= r_yb))
    `BRFE_ASSERT(a_boot_silent, i_clk, i_rst_n, r_boot |-> !o_done.vld)

endmodule

/* rtl/bitmap_rect_fill_engine.sv */
// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------
// request   | start / busy          | i_req (t_req)
// result    | o_strobe, one cycle   | o_res (t_res)
// config    | i_cfg_valid/o_cfg_ready | i_cfg_data (pixel op)
//
// fill: one byte per cycle, strobe after the last byte is written back
// clear zeroes every byte in turn; read and write access a single byte
// in a fill each in-range byte is read and written back through the memory's read and write ports
// after reset busy stays high while the memory is zeroed
// config is always taken; the result strobe cannot be stalled
module bitmap_rect_fill_engine
    import brfe_pkg::*;
#(
    parameter int BITMAP_BYTES = 6144
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_strobe,
    output t_res       o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic [1:0] r_pix_op;
    logic       r_strobe;
    t_res       r_res;
    t_mem_req   mem_req;
    t_done      done;
    logic [7:0] rd_data;
    logic       ctrl_busy;

    brfe_ctrl #(
        .BITMAP_BYTES(BITMAP_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req),
        .i_pix_op   (r_pix_op),
        .i_rd_data  (rd_data),
        .o_mem      (mem_req),
        .o_done     (done),
        .o_busy     (ctrl_busy)
    );

    brfe_mem #(
        .BITMAP_BYTES(BITMAP_BYTES)
    ) u_mem (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_rd_data(rd_data)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_op <= PM_SET;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pix_op <= i_cfg_data;
            end
            r_strobe <= done.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done.vld) begin
            r_res <= done.res;
        end
    end

    assign busy     = ctrl_busy;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* verif/tb_bitmap_rect_fill_engine.sv */
`timescale 1ns / 100ps

module tb_bitmap_rect_fill_engine
    import brfe_pkg::*;
();

    localparam int          BITMAP_BYTES = 6144;
    localparam int          IDLE_LIMIT   = 40000;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 70;
    localparam logic [1:0]  PM_SET_ALT   = 2'd3;

    class bitmap_mirror;
        bit [7:0]   pixels [BITMAP_BYTES];
        bit [1:0]   pix_op;
        bit [7:0]   last_row;
        bit [4:0]   last_col;
        t_res       pending_results [$];
        int         mismatches;
        int         results_checked;
        int         n_fill, n_clear, n_read, n_write;

        function new();
            foreach (pixels[i]) pixels[i] = 8'h00;
            pix_op = PM_SET;
            last_row = 8'd0;
            last_col = 5'd0;
        endfunction

        function void set_mode(logic [1:0] m);
            pix_op = m;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void plot(int addr, bit [7:0] mask);
            if (addr >= BITMAP_BYTES) return;
            case (pix_op)
                PM_RESET:  pixels[addr] = pixels[addr] & ~mask;
                PM_INVERT: pixels[addr] = pixels[addr] ^ mask;
                default:   pixels[addr] = pixels[addr] | mask;
            endcase
        endfunction

        function void note_request(t_req r);
            t_res     e;
            int       xa, xb, ya, yb, cx0, cx1, b0, b1, base;
            bit [7:0] mask;
            e.request_echo = r.req_type;
            e.read_value = 8'h00;
            case (r.req_type)
                REQ_FILL: begin
                    n_fill++;
                    xa = r.x_first;  xb = r.x_second;
                    ya = r.y_first;  yb = r.y_second;
                    if (xb < xa) begin
                        xa = r.x_second;  xb = r.x_first;
                    end
                    if (yb < ya) begin
                        ya = r.y_second;  yb = r.y_first;
                    end
                    cx0 = xa >> 3;  b0 = xa & 7;
                    cx1 = xb >> 3;  b1 = xb & 7;
                    for (int y = ya; y <= yb; y++) begin
                        base = (y & 'hF8) * 32 + (y & 7);
                        if (cx0 == cx1) begin
                            mask = (8'hFF >> b0) & (8'hFF << (7 - b1));
                            plot(base + cx0 * 8, mask);
                        end else begin
                            mask = 8'hFF >> b0;
                            plot(base + cx0 * 8, mask);
                            for (int cx = cx0 + 1; cx < cx1; cx++)
                                plot(base + cx * 8, 8'hFF);
                            mask = 8'hFF << (7 - b1);
                            plot(base + cx1 * 8, mask);
                        end
                    end
                    last_row = yb[7:0];
                    last_col = cx1[4:0];
                end
                REQ_CLEAR: begin
                    n_clear++;
                    foreach (pixels[i]) pixels[i] = 8'h00;
                end
                REQ_READ: begin
                    n_read++;
                    if (r.byte_address < BITMAP_BYTES)
                        e.read_value = pixels[r.byte_address];
                end
                default: begin
                    n_write++;
                    if (r.byte_address < BITMAP_BYTES)
                        pixels[r.byte_address] = r.byte_value;
                end
            endcase
            pending_results.push_back(e);
        endfunction

        function void report(string what, t_res e, t_res got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: expected echo %0d value %02h, got echo %0d value %02h",
                         $realtime, what, e.request_echo, e.read_value,
                         got.request_echo, got.read_value);
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending_results.size() == 0) begin
                e = '0;
                report("unexpected word", e, got);
                return;
            end
            e = pending_results.pop_front();
            results_checked++;
            if (got.request_echo !== e.request_echo || got.read_value !== e.read_value)
                report("result mismatch", e, got);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_strobe;
    t_res       o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data;

    bitmap_mirror mirror = new();
    int           idle_cycles;
    int           lx0, lx1, ly0, ly1;
    bit [3:0]     modes_seen;

    bitmap_rect_fill_engine #(.BITMAP_BYTES(BITMAP_BYTES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            mirror.check_result(o_res);
    end

    // watchdog: any handshake counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1 ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_req mk(logic [1:0] kind, int xa, int ya, int xb, int yb,
                                int addr, int val);
        t_req r;
        r.req_type     = kind;
        r.x_first      = xa[7:0];
        r.y_first      = ya[7:0];
        r.x_second     = xb[7:0];
        r.y_second     = yb[7:0];
        r.byte_address = addr[12:0];
        r.byte_value   = val[7:0];
        return r;
    endfunction

    function automatic int tile_addr(int x, int y);
        return (y & 'hF8) * 32 + (x & 'hF8) + (y & 7);
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick, sz, xa, xb, ya, yb, t;
        r = mk(REQ_FILL, $urandom_range(0, 255), $urandom_range(0, 191),
               $urandom_range(0, 255), $urandom_range(0, 191),
               $urandom_range(0, BITMAP_BYTES - 1), $urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            sz = $urandom_range(0, 99);
            if (sz < 90) begin
                xa = $urandom_range(0, 255);
                ya = $urandom_range(0, 191);
                xb = xa + $urandom_range(0, 23);
                yb = ya + $urandom_range(0, 11);
                if (xb > 255) xb = 255;
                if (yb > 191) yb = 191;
            end else if (sz < 97) begin
                xa = r.x_first;   xb = r.x_second;
                ya = r.y_first;   yb = r.y_second;
            end else begin
                xa = $urandom_range(0, 1) ? 255 : 0;
                xb = 255 - xa;
                ya = $urandom_range(0, 1) ? 191 : 0;
                yb = 191 - ya;
            end
            if ($urandom_range(0, 1)) begin
                t = xa;  xa = xb;  xb = t;
            end
            if ($urandom_range(0, 1)) begin
                t = ya;  ya = yb;  yb = t;
            end
            r.x_first = xa[7:0];  r.x_second = xb[7:0];
            r.y_first = ya[7:0];  r.y_second = yb[7:0];
            lx0 = (xa < xb) ? xa : xb;  lx1 = (xa < xb) ? xb : xa;
            ly0 = (ya < yb) ? ya : yb;  ly1 = (ya < yb) ? yb : ya;
        end else if (pick < 41) begin
            r.req_type = REQ_CLEAR;
        end else begin
            r.req_type = (pick < 84) ? REQ_READ : REQ_WRITE;
            case ($urandom_range(0, 9))
                0:       t = 0;
                1:       t = BITMAP_BYTES - 1;
                2, 3, 4: t = r.byte_address;
                default: t = tile_addr($urandom_range(lx0, lx1), $urandom_range(ly0, ly1));
            endcase
            r.byte_address = t[12:0];
        end
        return r;
    endfunction

    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // gap > 0 drops start after the accept; gap == 0 keeps it high for the next word
    task automatic send_request(t_req r, int gap);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        mirror.note_request(r);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (mirror.pending() > 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        mirror.set_mode(m);
        modes_seen[m] = 1'b1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [1:0] phase_mode [PHASES];
        bit         no_gaps;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = PM_SET;
        modes_seen  = '0;
        lx0 = 0;  lx1 = 255;  ly0 = 0;  ly1 = 191;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // memory is zeroed after reset before busy drops
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        write_mode(PM_SET);

        send_request(mk(REQ_READ,  0, 0, 0, 0, BITMAP_BYTES - 1, 0), 1);
        send_request(mk(REQ_WRITE, 0, 0, 0, 0, 0, 'hA5), 0);
        send_request(mk(REQ_WRITE, 0, 0, 0, 0, BITMAP_BYTES - 1, 'h5A), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, 0, 0), 2);
        send_request(mk(REQ_READ,  0, 0, 0, 0, BITMAP_BYTES - 1, 0), 0);
        send_request(mk(REQ_FILL,  255, 191, 255, 191, 0, 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, BITMAP_BYTES - 1, 0), 0);
        send_request(mk(REQ_FILL,  14, 12, 9, 9, 0, 0), 1);
        send_request(mk(REQ_READ,  0, 0, 0, 0, tile_addr(9, 10), 0), 0);
        send_request(mk(REQ_FILL,  5, 0, 10, 0, 0, 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, 0, 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, 8, 0), 3);
        send_request(mk(REQ_FILL,  0, 0, 255, 191, 0, 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, 3000, 0), 0);
        send_request(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, BITMAP_BYTES - 1, 0), 1);
        drain();
        write_mode(PM_INVERT);
        send_request(mk(REQ_FILL,  200, 100, 3, 5, 0, 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, tile_addr(100, 50), 0), 0);
        send_request(mk(REQ_FILL,  0, 0, 255, 191, 0, 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, tile_addr(100, 50), 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, 0, 0), 1);
        drain();
        write_mode(PM_RESET);
        send_request(mk(REQ_FILL,  0, 0, 127, 95, 0, 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, 0, 0), 1);
        drain();
        write_mode(PM_SET_ALT);
        send_request(mk(REQ_FILL,  3, 3, 3, 3, 0, 0), 0);
        send_request(mk(REQ_READ,  0, 0, 0, 0, 3, 0), 1);

        phase_mode[0] = PM_INVERT;
        phase_mode[1] = PM_RESET;
        phase_mode[2] = PM_SET_ALT;
        phase_mode[3] = PM_SET;
        for (int p = 4; p < PHASES; p++) phase_mode[p] = 2'($urandom_range(0, 3));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_mode(phase_mode[p]);
            no_gaps = (p % 3 == 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_request(random_request(), no_gaps ? 0 : random_gap());
                if ($urandom_range(0, 99) < 3) drain();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d fills, %0d clears, %0d reads, %0d writes; pixel ops seen %b",
                 mirror.n_fill, mirror.n_clear, mirror.n_read, mirror.n_write, modes_seen);
        $display("%0d results checked, %0d mismatches", mirror.results_checked,
                 mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
